// File: hw/rtl/assert_macros.svh
// assertion macros used by the rtl datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// condition that must hold whenever the trigger is seen
`define ASSERT_IMPLY(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("assertion failed");

`endif

// File: hw/rtl/alc_pkg.sv
// types and constants shared by the array list blocks
package alc_pkg;

	localparam int unsigned DataW       = 32;
	localparam int unsigned CountW      = 7;
	localparam int unsigned DefCapacity = 64;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_FIRST  = 2'd1,
		ACT_NEXT   = 2'd2,
		ACT_REMOVE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NONE     = 2'd2,
		ST_NOCURSOR = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		RD_ZERO  = 3'd0,
		RD_NEXT  = 3'd1,
		RD_CUR   = 3'd2,
		RD_AFTER = 3'd3,
		RD_SHIFT = 3'd4
	} rd_sel_t;

	typedef enum logic [1:0] {
		CUR_HOLD = 2'd0,
		CUR_ZERO = 2'd1,
		CUR_INC  = 2'd2,
		CUR_DEC  = 2'd3
	} cur_op_t;

	typedef struct packed {
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		logic    wr_shift;
		logic    cnt_inc;
		logic    cnt_dec;
		cur_op_t cur_op;
		logic    sh_init;
		logic    sh_inc;
		logic    out_load;
		logic    out_data;
		status_t out_status;
	} ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic next_ok;
		logic cur_ok;
		logic remove_last;
		logic shift_last;
		logic out_free;
	} stat_t;

endpackage

// File: hw/rtl/alc_if.sv
// request and response channel interfaces of the array list
interface alc_in_if;
	import alc_pkg::*;

	logic                     valid;
	logic                     ready;
	action_t                  action;
	logic signed [DataW-1:0]  item_value;

	modport source (output valid, action, item_value, input ready);
	modport sink (input valid, action, item_value, output ready);
endinterface

interface alc_out_if;
	import alc_pkg::*;

	logic                     valid;
	logic                     ready;
	status_t                  status;
	logic signed [DataW-1:0]  data_out;
	logic [CountW-1:0]        item_count;

	modport source (output valid, status, data_out, item_count, input ready);
	modport sink (input valid, status, data_out, item_count, output ready);
endinterface

// File: hw/rtl/alc_ctrl.sv
// controller state machine sequencing each list request
module alc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	alc_in_if.sink         req,
	input  alc_pkg::stat_t sts,
	output alc_pkg::ctl_t  ctl
);
	import alc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_READ   = 4'b0010,
		S_REMOVE = 4'b0100,
		S_SHIFT  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   in_ready;

	assign req.ready = in_ready;

	always_comb begin
		ctl      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = sts.out_free;
				if (req.valid && sts.out_free) begin
					unique case (req.action)
						ACT_INSERT: begin
							ctl.out_load = 1'b1;
							if (sts.full) begin
								ctl.out_status = ST_FULL;
							end else begin
								ctl.wr_en   = 1'b1;
								ctl.cnt_inc = 1'b1;
							end
						end
						ACT_FIRST: begin
							if (sts.empty) begin
								ctl.out_load   = 1'b1;
								ctl.out_status = ST_NONE;
							end else begin
								ctl.rd_en  = 1'b1;
								ctl.rd_sel = RD_ZERO;
								ctl.cur_op = CUR_ZERO;
								state_d    = S_READ;
							end
						end
						ACT_NEXT: begin
							if (!sts.next_ok) begin
								ctl.out_load   = 1'b1;
								ctl.out_status = ST_NONE;
							end else begin
								ctl.rd_en  = 1'b1;
								ctl.rd_sel = RD_NEXT;
								ctl.cur_op = CUR_INC;
								state_d    = S_READ;
							end
						end
						ACT_REMOVE: begin
							if (!sts.cur_ok) begin
								ctl.out_load   = 1'b1;
								ctl.out_status = ST_NOCURSOR;
							end else begin
								ctl.rd_en  = 1'b1;
								ctl.rd_sel = RD_CUR;
								state_d    = S_REMOVE;
							end
						end
						default: ;
					endcase
				end
			end
			S_READ: begin
				ctl.out_load = 1'b1;
				ctl.out_data = 1'b1;
				state_d      = S_IDLE;
			end
			S_REMOVE: begin
				ctl.out_load = 1'b1;
				ctl.out_data = 1'b1;
				ctl.cnt_dec  = 1'b1;
				ctl.cur_op   = CUR_DEC;
				if (sts.remove_last) begin
					state_d = S_IDLE;
				end else begin
					// fetch the first entry that moves down
					ctl.rd_en   = 1'b1;
					ctl.rd_sel  = RD_AFTER;
					ctl.sh_init = 1'b1;
					state_d     = S_SHIFT;
				end
			end
			S_SHIFT: begin
				ctl.wr_en    = 1'b1;
				ctl.wr_shift = 1'b1;
				ctl.sh_inc   = 1'b1;
				if (sts.shift_last) begin
					state_d = S_IDLE;
				end else begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = RD_SHIFT;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hw/rtl/alc_datapath.sv
// entry memory, count, cursor and response register of the array list
`include "assert_macros.svh"

module alc_datapath #(
	parameter int unsigned CAPACITY = alc_pkg::DefCapacity
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic signed [alc_pkg::DataW-1:0] item_value,
	input  alc_pkg::ctl_t                    ctl,
	output alc_pkg::stat_t                   sts,
	alc_out_if.source                        rsp
);
	import alc_pkg::*;

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic signed [DataW-1:0] entry_mem_q [CAPACITY];
	logic signed [DataW-1:0] rd_data_q;
	logic [CW-1:0]           count_q, count_next;
	logic                    cur_valid_q, cur_valid_next;
	logic [AW-1:0]           cur_q, cur_next;
	logic [AW-1:0]           sh_q;
	logic [AW-1:0]           rd_addr, wr_addr;
	logic signed [DataW-1:0] wr_data;
	logic [CW-1:0]           cur_ext, cur_inc_ext, sh_inc_ext;

	logic                    out_valid_q;
	status_t                 out_status_q;
	logic signed [DataW-1:0] out_data_q;
	logic [CountW-1:0]       out_count_q;

	assign cur_ext     = CW'(cur_q);
	assign cur_inc_ext = cur_ext + CW'(1);
	assign sh_inc_ext  = CW'(sh_q) + CW'(1);

	// status toward the controller
	assign sts.full        = (count_q == CW'(CAPACITY));
	assign sts.empty       = (count_q == '0);
	assign sts.next_ok     = cur_valid_q ? (cur_inc_ext < count_q) : (count_q != '0);
	assign sts.cur_ok      = cur_valid_q && (cur_ext < count_q);
	assign sts.remove_last = (cur_inc_ext == count_q);
	assign sts.shift_last  = (sh_inc_ext == count_q);
	assign sts.out_free    = !out_valid_q || rsp.ready;

	always_comb begin
		unique case (ctl.rd_sel)
			RD_ZERO:  rd_addr = '0;
			RD_NEXT:  rd_addr = cur_valid_q ? AW'(cur_inc_ext) : '0;
			RD_CUR:   rd_addr = cur_q;
			RD_AFTER: rd_addr = AW'(cur_inc_ext);
			RD_SHIFT: rd_addr = AW'(sh_inc_ext + CW'(1));
			default:  rd_addr = '0;
		endcase
	end

	// insert appends at the count, the shift sweep moves an entry down one place
	assign wr_addr = ctl.wr_shift ? sh_q : AW'(count_q);
	assign wr_data = ctl.wr_shift ? rd_data_q : item_value;

	always_comb begin
		count_next = count_q;
		if (ctl.cnt_inc) begin
			count_next = count_q + CW'(1);
		end else if (ctl.cnt_dec) begin
			count_next = count_q - CW'(1);
		end
	end

	always_comb begin
		cur_valid_next = cur_valid_q;
		cur_next       = cur_q;
		unique case (ctl.cur_op)
			CUR_HOLD: ;
			CUR_ZERO: begin
				cur_valid_next = 1'b1;
				cur_next       = '0;
			end
			CUR_INC: begin
				cur_valid_next = 1'b1;
				cur_next       = cur_valid_q ? AW'(cur_inc_ext) : '0;
			end
			CUR_DEC: begin
				// stepping back from the head leaves no position
				if (cur_q == '0) begin
					cur_valid_next = 1'b0;
				end else begin
					cur_next = cur_q - AW'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			entry_mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= entry_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q     <= count_next;
			cur_valid_q <= cur_valid_next;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_next;
		if (ctl.sh_init) begin
			sh_q <= cur_q;
		end else if (ctl.sh_inc) begin
			sh_q <= sh_q + AW'(1);
		end
		if (ctl.out_load) begin
			out_status_q <= ctl.out_status;
			out_data_q   <= ctl.out_data ? rd_data_q : '0;
			out_count_q  <= CountW'(count_next);
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.data_out   = out_data_q;
	assign rsp.item_count = out_count_q;

	`ASSERT_IMPLY(a_cursor_in_list, cur_valid_q, cur_ext < count_q)
	`ASSERT_ALWAYS(a_count_bound, count_q <= CW'(CAPACITY))
	`ASSERT_IMPLY(a_load_when_free, ctl.out_load, !out_valid_q || rsp.ready)
	`ASSERT_IMPLY(a_no_port_clash, ctl.wr_en && ctl.rd_en, wr_addr != rd_addr)

endmodule

// File: hw/rtl/array_list_with_cursor_top.sv
// top level of the array list with read cursor
// The list keeps up to CAPACITY signed 32-bit entries in a simple dual-port memory
// (one write and one registered read per cycle). Each request gives one response,
// held in an output register; a new request is taken only when that register is empty
// or its response leaves in the same cycle. An insert, or any request that ends in
// an error status, is answered from the idle state; first and next pass through a
// read state for the memory read. A remove reads the entry at the cursor; after
// that read, later entries move down one per cycle through the memory port,
// and the response is offered while that sweep runs. The memory needs no clearing
// after reset; only entries below the count at request time are ever read.
module array_list_with_cursor_top #(
	parameter int unsigned CAPACITY = alc_pkg::DefCapacity
) (
	input  logic      clk,
	input  logic      arst_n,
	alc_in_if.sink    cmd,
	alc_out_if.source rsp
);
	import alc_pkg::*;

	ctl_t  ctl;
	stat_t sts;

	alc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cmd),
		.sts    (sts),
		.ctl    (ctl)
	);

	alc_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_value (cmd.item_value),
		.ctl        (ctl),
		.sts        (sts),
		.rsp        (rsp)
	);

endmodule

// File: tb/tb_array_list_with_cursor_top.sv
// self-checking testbench for the array list with read cursor
module tb_array_list_with_cursor_top;
	import alc_pkg::*;

	localparam int unsigned LIST_CAP = DefCapacity;
	localparam int ITEMS       = 1250;
	localparam int CALM_FROM   = 1050;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DIR_ROWS    = 25;

	typedef struct packed {
		status_t                 status;
		logic signed [DataW-1:0] data;
		logic [CountW-1:0]       count;
	} list_reply_t;

	typedef struct {
		action_t                 act;
		logic signed [DataW-1:0] val;
		bit                      typed;
		list_reply_t             want;
	} dir_row_t;

	typedef enum {MIX_FILL, MIX_WALK, MIX_DRAIN} op_mix_t;

	logic clk;
	logic arst_n;

	alc_in_if  cmd_if();
	alc_out_if rsp_if();

	array_list_with_cursor_top #(.CAPACITY(LIST_CAP)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	// shadow copy of the list
	logic signed [DataW-1:0] list_mem [LIST_CAP];
	int                      shadow_fill;
	int                      cursor_pos;

	list_reply_t replies_due [$];
	int          mismatches;
	int          cycle_cnt;
	bit          calm;

	// directed rows; untyped rows take their expectation from the shadow list
	dir_row_t dir_tab [DIR_ROWS] = '{
		'{ACT_FIRST,  32'sd0,            1'b1, '{ST_NONE,     32'sd0,            7'd0}},
		'{ACT_NEXT,   32'sd0,            1'b1, '{ST_NONE,     32'sd0,            7'd0}},
		'{ACT_REMOVE, 32'sd0,            1'b1, '{ST_NOCURSOR, 32'sd0,            7'd0}},
		'{ACT_INSERT, 32'sh7fffffff,     1'b1, '{ST_OK,       32'sd0,            7'd1}},
		'{ACT_INSERT, 32'sh80000000,     1'b1, '{ST_OK,       32'sd0,            7'd2}},
		'{ACT_INSERT, 32'sd0,            1'b1, '{ST_OK,       32'sd0,            7'd3}},
		'{ACT_INSERT, 32'shffffffff,     1'b1, '{ST_OK,       32'sd0,            7'd4}},
		// next with no position starts at entry 0
		'{ACT_NEXT,   32'sd0,            1'b1, '{ST_OK,       32'sh7fffffff,     7'd4}},
		'{ACT_NEXT,   32'sd0,            1'b1, '{ST_OK,       32'sh80000000,     7'd4}},
		'{ACT_REMOVE, 32'sh12345678,     1'b1, '{ST_OK,       32'sh80000000,     7'd3}},
		'{ACT_NEXT,   32'sd0,            1'b0, '{ST_OK,       32'sd0,            7'd0}},
		'{ACT_NEXT,   32'sd0,            1'b0, '{ST_OK,       32'sd0,            7'd0}},
		'{ACT_NEXT,   32'sd0,            1'b1, '{ST_NONE,     32'sd0,            7'd3}},
		'{ACT_REMOVE, 32'sd0,            1'b1, '{ST_OK,       32'shffffffff,     7'd2}},
		'{ACT_FIRST,  32'sd0,            1'b1, '{ST_OK,       32'sh7fffffff,     7'd2}},
		// removing entry 0 leaves no position
		'{ACT_REMOVE, 32'sd0,            1'b1, '{ST_OK,       32'sh7fffffff,     7'd1}},
		'{ACT_REMOVE, 32'sd0,            1'b1, '{ST_NOCURSOR, 32'sd0,            7'd1}},
		'{ACT_INSERT, 32'sh5a5a5a5a,     1'b1, '{ST_OK,       32'sd0,            7'd2}},
		'{ACT_INSERT, 32'sha5a5a5a5,     1'b1, '{ST_OK,       32'sd0,            7'd3}},
		'{ACT_NEXT,   32'sd0,            1'b0, '{ST_OK,       32'sd0,            7'd0}},
		'{ACT_REMOVE, 32'sd0,            1'b0, '{ST_OK,       32'sd0,            7'd0}},
		'{ACT_FIRST,  32'sd0,            1'b1, '{ST_OK,       32'sh5a5a5a5a,     7'd2}},
		'{ACT_NEXT,   32'sd0,            1'b1, '{ST_OK,       32'sha5a5a5a5,     7'd2}},
		'{ACT_REMOVE, 32'sd0,            1'b1, '{ST_OK,       32'sha5a5a5a5,     7'd1}},
		'{ACT_REMOVE, 32'sd0,            1'b1, '{ST_OK,       32'sh5a5a5a5a,     7'd0}}
	};

	function automatic list_reply_t predict_list_op(action_t act, logic signed [DataW-1:0] val);
		list_reply_t r;
		r.status = ST_OK;
		r.data   = '0;
		case (act)
			ACT_INSERT: begin
				if (shadow_fill >= LIST_CAP) begin
					r.status = ST_FULL;
				end else begin
					list_mem[shadow_fill] = val;
					shadow_fill++;
				end
			end
			ACT_FIRST: begin
				if (shadow_fill == 0) begin
					r.status = ST_NONE;
				end else begin
					cursor_pos = 0;
					r.data     = list_mem[0];
				end
			end
			ACT_NEXT: begin
				if (cursor_pos >= shadow_fill - 1) begin
					r.status = ST_NONE;
				end else begin
					cursor_pos++;
					r.data = list_mem[cursor_pos];
				end
			end
			default: begin
				if (cursor_pos < 0 || cursor_pos >= shadow_fill) begin
					r.status = ST_NOCURSOR;
				end else begin
					r.data = list_mem[cursor_pos];
					for (int i = cursor_pos; i < shadow_fill - 1; i++)
						list_mem[i] = list_mem[i + 1];
					cursor_pos--;
					shadow_fill--;
				end
			end
		endcase
		r.count = CountW'(shadow_fill);
		return r;
	endfunction

	// offer one request and hold it until the transfer; valid stays high on return
	task automatic send_op(action_t act, logic signed [DataW-1:0] val, bit typed,
			list_reply_t want);
		list_reply_t predicted;
		if (!calm && $urandom_range(0, 5) == 0) begin
			cmd_if.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		cmd_if.valid      <= 1'b1;
		cmd_if.action     <= act;
		cmd_if.item_value <= val;
		@(posedge clk);
		while (!cmd_if.ready) @(posedge clk);
		predicted = predict_list_op(act, val);
		replies_due.push_back(typed ? want : predicted);
	endtask

	task automatic wait_drained();
		cmd_if.valid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d responses outstanding", $time, replies_due.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// response side stalls in bursts
	initial begin
		rsp_if.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (calm || $urandom_range(0, 2) != 0) begin
				rsp_if.ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		list_reply_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (replies_due.size() == 0) begin
				$display("%0t: response with none outstanding: status %s data %0d count %0d",
					$time, rsp_if.status.name(), rsp_if.data_out, rsp_if.item_count);
				mismatches++;
			end else begin
				want = replies_due.pop_front();
				if (rsp_if.status !== want.status) begin
					$display("%0t: status expected %s actual %s", $time,
						want.status.name(), rsp_if.status.name());
					mismatches++;
				end
				if (rsp_if.data_out !== want.data) begin
					$display("%0t: data_out expected %0d actual %0d", $time,
						want.data, rsp_if.data_out);
					mismatches++;
				end
				if (rsp_if.item_count !== want.count) begin
					$display("%0t: item_count expected %0d actual %0d", $time,
						want.count, rsp_if.item_count);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int                      sent;
		int                      phase_len;
		int                      phase_no;
		int                      pick;
		op_mix_t                 mix;
		action_t                 act;
		logic signed [DataW-1:0] val;

		mismatches  = 0;
		cycle_cnt   = 0;
		calm        = 1'b0;
		shadow_fill = 0;
		cursor_pos  = -1;
		arst_n            <= 1'b0;
		cmd_if.valid      <= 1'b0;
		cmd_if.action     <= ACT_INSERT;
		cmd_if.item_value <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_op(dir_tab[i].act, dir_tab[i].val, dir_tab[i].typed, dir_tab[i].want);
		wait_drained();

		sent     = 0;
		phase_no = 0;
		while (sent < ITEMS) begin
			mix       = op_mix_t'(phase_no % 3);
			phase_len = $urandom_range(60, 140);
			for (int k = 0; k < phase_len && sent < ITEMS; k++) begin
				calm = (sent >= CALM_FROM);
				pick = $urandom_range(0, 99);
				case (mix)
					MIX_FILL:
						act = pick < 80 ? ACT_INSERT : pick < 87 ? ACT_FIRST :
							pick < 94 ? ACT_NEXT : ACT_REMOVE;
					MIX_WALK:
						act = pick < 25 ? ACT_INSERT : pick < 35 ? ACT_FIRST :
							pick < 75 ? ACT_NEXT : ACT_REMOVE;
					default:
						act = pick < 8 ? ACT_INSERT : pick < 20 ? ACT_FIRST :
							pick < 45 ? ACT_NEXT : ACT_REMOVE;
				endcase
				case ($urandom_range(0, 7))
					0:       val = 32'sh7fffffff;
					1:       val = 32'sh80000000;
					2:       val = '0;
					3:       val = '1;
					default: val = $urandom;
				endcase
				send_op(act, val, 1'b0, '0);
				sent++;
			end
			// let the pipeline empty out before the next mix
			wait_drained();
			phase_no++;
		end

		wait_drained();
		repeat (LIST_CAP + 8) @(posedge clk);
		if (mismatches == 0 && replies_due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
